/* design/tmbm_pkg.sv */
// ----------------------------------------------------------------------------
// tmbm_pkg
// shared widths, constants and item types of the trimmed-mean battery monitor
// ----------------------------------------------------------------------------
package tmbm_pkg;

    // samples per window
    localparam int WINDOW   = 34;
    localparam int CNT_W    = $clog2(WINDOW);

    localparam int SAMPLE_W = 10;
    localparam int STOP_W   = 8;
    localparam int RST_W    = 10;
    localparam int SUM_W    = 16;
    localparam int MV_W     = 15;
    localparam int LEVEL_W  = 2;
    localparam int IDX_W    = 2;
    localparam int MV_SHIFT = 15;
    localparam int PROD_W   = SUM_W + MV_W;

    // millivolt scaling: 800 + trimmed * 20030 >> 15
    localparam logic [MV_W-1:0]   MV_OFFSET    = 15'd800;
    localparam logic [MV_W-1:0]   MV_SCALE     = 15'd20030;
    localparam logic [MV_W-1:0]   MV_MAX       = 15'd32767;
    localparam logic [MV_W-1:0]   MOVE_MV      = 15'd100;
    localparam logic [STOP_W-1:0] STORE_STOP   = 8'd3;
    localparam logic [STOP_W-1:0] CHARGE_STOP  = 8'd5;
    localparam logic [RST_W-1:0]  CHARGE_RESET = 10'd250;

    // threshold reset values
    localparam logic [MV_W-1:0] LOW_MV_RST    = 15'd10500;
    localparam logic [MV_W-1:0] MID_MV_RST    = 15'd11100;
    localparam logic [MV_W-1:0] FULL_MV_RST   = 15'd12000;
    localparam logic [MV_W-1:0] LOWEST_MV_RST = 15'd10000;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_MV,
        REG_MID_MV,
        REG_FULL_MV,
        REG_LOWEST_MV
    } cfg_idx_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_EMPTY,
        LEVEL_LOW,
        LEVEL_MID,
        LEVEL_FULL
    } level_t;

    typedef struct packed {
        logic [MV_W-1:0] low_mv;
        logic [MV_W-1:0] mid_mv;
        logic [MV_W-1:0] full_mv;
        logic [MV_W-1:0] lowest_mv;
    } thresh_t;

    // window-end item from the accumulator
    typedef struct packed {
        logic [SUM_W-1:0] trimmed;
        logic             store_en;
        logic             charge_gate;
    } window_t;

    // scaled voltage item towards the grading stage
    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            store_en;
        logic            charge_gate;
    } scaled_t;

endpackage

/* design/trimmed_mean_battery_monitor.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_battery_monitor
// olympic-filtered battery voltage with band level, move and charge flags
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless m_ready back-pressure stalls the pipeline; one result per WINDOW items (34)
// path of a window's last item to its result, register by register:
//   input register, accumulator, multiply, offset/saturate, grading register
// reset (aresetn, synchronous, active low): window empty, stored and reported
//   voltage 0, level 0, thresholds to their defaults, pipeline empty
// ----------------------------------------------------------------------------
module trimmed_mean_battery_monitor
    import tmbm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [IDX_W-1:0]    cfg_addr,
    input  logic [MV_W-1:0]     cfg_wr_data,

    // sample items in
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                s_source_off,
    input  logic [STOP_W-1:0]   s_stop_time,
    input  logic [RST_W-1:0]    s_reset_time,

    // result items out
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MV_W-1:0]     m_voltage_mv,
    output logic [LEVEL_W-1:0]  m_level,
    output logic                m_level_changed,
    output logic                m_voltage_moved,
    output logic                m_charge_request
);

    // threshold registers
    thresh_t             thresh_reg;

    // input register stage
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                source_off_reg;
    logic [STOP_W-1:0]   stop_time_reg;
    logic [RST_W-1:0]    reset_time_reg;
    logic                acc_ready;

    // between the stages
    logic                win_valid;
    window_t             win;
    logic                win_ready;
    logic                scaled_valid;
    scaled_t             scaled;
    logic                scaled_ready;

    // configuration writes, decoded by register index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.low_mv    <= LOW_MV_RST;
            thresh_reg.mid_mv    <= MID_MV_RST;
            thresh_reg.full_mv   <= FULL_MV_RST;
            thresh_reg.lowest_mv <= LOWEST_MV_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_LOW_MV:    thresh_reg.low_mv    <= cfg_wr_data;
                REG_MID_MV:    thresh_reg.mid_mv    <= cfg_wr_data;
                REG_FULL_MV:   thresh_reg.full_mv   <= cfg_wr_data;
                REG_LOWEST_MV: thresh_reg.lowest_mv <= cfg_wr_data;
                default:       thresh_reg           <= thresh_reg;
            endcase
        end
    end

    // input register: free when empty or whenever the accumulator takes its item
    assign s_ready = !in_valid_reg || acc_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg     <= s_sample;
            source_off_reg <= s_source_off;
            stop_time_reg  <= s_stop_time;
            reset_time_reg <= s_reset_time;
        end
    end

    // sum, min and max over the window; trimmed sum on the last item
    tmbm_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid_reg),
        .in_sample     (sample_reg),
        .in_source_off (source_off_reg),
        .in_stop_time  (stop_time_reg),
        .in_reset_time (reset_time_reg),
        .in_ready      (acc_ready),
        .win_valid     (win_valid),
        .win           (win),
        .win_ready     (win_ready)
    );

    // constant multiply, then offset and saturation to 15 bits
    tmbm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_item   (win),
        .in_ready  (win_ready),
        .out_valid (scaled_valid),
        .out_item  (scaled),
        .out_ready (scaled_ready)
    );

    // stored voltage update, grading and the result register
    tmbm_grade u_grade (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (scaled_valid),
        .in_item            (scaled),
        .in_ready           (scaled_ready),
        .thresh             (thresh_reg),
        .out_valid          (m_valid),
        .out_ready          (m_ready),
        .out_voltage_mv     (m_voltage_mv),
        .out_level          (m_level),
        .out_level_changed  (m_level_changed),
        .out_voltage_moved  (m_voltage_moved),
        .out_charge_request (m_charge_request)
    );

endmodule

/* design/tmbm_accum.sv */
// ----------------------------------------------------------------------------
// tmbm_accum
// running sum, minimum and maximum over one window; trimmed sum at window end
// ----------------------------------------------------------------------------
module tmbm_accum
    import tmbm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic                in_source_off,
    input  logic [STOP_W-1:0]   in_stop_time,
    input  logic [RST_W-1:0]    in_reset_time,
    output logic                in_ready,
    output logic                win_valid,
    output window_t             win,
    input  logic                win_ready
);

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]    count_reg;
    logic                win_valid_reg;
    window_t             win_reg, win_next;
    logic                take;
    logic                last;

    assign in_ready = !win_valid_reg || win_ready;
    assign take     = in_valid && in_ready;
    assign last     = (count_reg == CNT_W'(WINDOW - 1));

    always_comb begin
        sum_next = sum_reg + SUM_W'(in_sample);
        min_next = (in_sample < min_reg) ? in_sample : min_reg;
        max_next = (in_sample > max_reg) ? in_sample : max_reg;
        win_next.trimmed     = sum_next - SUM_W'(min_next) - SUM_W'(max_next);
        win_next.store_en    = in_source_off && (in_stop_time >= STORE_STOP);
        win_next.charge_gate = in_source_off && (in_reset_time > CHARGE_RESET)
                               && (in_stop_time >= CHARGE_STOP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            count_reg     <= '0;
            win_valid_reg <= 1'b0;
        end else begin
            // a new window item wins over the hand-off of the old one
            if (take && last) begin
                win_valid_reg <= 1'b1;
            end else if (win_ready) begin
                win_valid_reg <= 1'b0;
            end
            if (take) begin
                if (last) begin
                    sum_reg   <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    sum_reg   <= sum_next;
                    min_reg   <= min_next;
                    max_reg   <= max_next;
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && last) begin
            win_reg <= win_next;
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;

endmodule

/* design/tmbm_scale.sv */
// ----------------------------------------------------------------------------
// tmbm_scale
// trimmed sum to millivolts: constant multiply, then offset and saturation
// ----------------------------------------------------------------------------
module tmbm_scale
    import tmbm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  window_t in_item,
    output logic    in_ready,
    output logic    out_valid,
    output scaled_t out_item,
    input  logic    out_ready
);

    localparam int HI_W = PROD_W - MV_SHIFT;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              prod_store_reg;
    logic              prod_gate_reg;
    logic              prod_valid_reg;
    logic              prod_ready;
    logic [HI_W:0]     mv_wide;
    scaled_t           mv_reg, mv_next;
    logic              mv_valid_reg;

    assign prod_ready = !mv_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign prod_next  = PROD_W'(in_item.trimmed) * PROD_W'(MV_SCALE);

    always_comb begin
        mv_wide = (HI_W + 1)'(prod_reg[PROD_W-1:MV_SHIFT]) + (HI_W + 1)'(MV_OFFSET);
        mv_next.mv          = (mv_wide > (HI_W + 1)'(MV_MAX)) ? MV_MAX : mv_wide[MV_W-1:0];
        mv_next.store_en    = prod_store_reg;
        mv_next.charge_gate = prod_gate_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            mv_valid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                mv_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg       <= prod_next;
            prod_store_reg <= in_item.store_en;
            prod_gate_reg  <= in_item.charge_gate;
        end
        if (prod_valid_reg && prod_ready) begin
            mv_reg <= mv_next;
        end
    end

    assign out_valid = mv_valid_reg;
    assign out_item  = mv_reg;

endmodule

/* design/tmbm_grade.sv */
// ----------------------------------------------------------------------------
// tmbm_grade
// stored voltage, band level, move and charge flags; result register
// ----------------------------------------------------------------------------
module tmbm_grade
    import tmbm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  scaled_t            in_item,
    output logic               in_ready,
    input  thresh_t            thresh,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MV_W-1:0]    out_voltage_mv,
    output logic [LEVEL_W-1:0] out_level,
    output logic               out_level_changed,
    output logic               out_voltage_moved,
    output logic               out_charge_request
);

    logic [MV_W-1:0]    stored_mv_reg;
    logic [MV_W-1:0]    reported_mv_reg;
    level_t             stored_level_reg;
    logic [MV_W-1:0]    mv_eff;
    level_t             level_next;
    logic               moved_next;
    logic               charge_next;
    logic               take;
    logic               out_valid_reg;
    logic [MV_W-1:0]    voltage_reg;
    level_t             level_reg;
    logic               changed_reg;
    logic               moved_reg;
    logic               charge_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        mv_eff      = in_item.store_en ? in_item.mv : stored_mv_reg;
        charge_next = in_item.charge_gate && (mv_eff < thresh.lowest_mv);
        // widened by one bit so the move compare cannot wrap
        moved_next  = ({1'b0, mv_eff} > ({1'b0, reported_mv_reg} + {1'b0, MOVE_MV}))
                   || ({1'b0, reported_mv_reg} > ({1'b0, mv_eff} + {1'b0, MOVE_MV}));
        if (mv_eff < thresh.low_mv) begin
            level_next = LEVEL_EMPTY;
        end else if (mv_eff < thresh.mid_mv) begin
            level_next = LEVEL_LOW;
        end else if (mv_eff < thresh.full_mv) begin
            level_next = LEVEL_MID;
        end else begin
            level_next = LEVEL_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_mv_reg    <= '0;
            reported_mv_reg  <= '0;
            stored_level_reg <= LEVEL_EMPTY;
            out_valid_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (take) begin
                stored_mv_reg    <= mv_eff;
                stored_level_reg <= level_next;
                if (moved_next) begin
                    reported_mv_reg <= mv_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            voltage_reg <= mv_eff;
            level_reg   <= level_next;
            changed_reg <= (level_next != stored_level_reg);
            moved_reg   <= moved_next;
            charge_reg  <= charge_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_voltage_mv     = voltage_reg;
    assign out_level          = level_reg;
    assign out_level_changed  = changed_reg;
    assign out_voltage_moved  = moved_reg;
    assign out_charge_request = charge_reg;

endmodule
